// ===== sv/word_tokenizer_filter_defines.svh =====
// ----------------------------------------------------------------------------
// word_tokenizer_filter_defines
// Assertion macros shared by the checker of the word tokenizer filter.
// ----------------------------------------------------------------------------
`ifndef WORD_TOKENIZER_FILTER_DEFINES_SVH
`define WORD_TOKENIZER_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define WTOK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define WTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wtok_pkg.sv =====
// ----------------------------------------------------------------------------
// wtok_pkg
// Shared types, constants and byte classifiers of the word tokenizer filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wtok_pkg;

  localparam int MAX_WORD_BYTES_DEF = 32;
  localparam int BYTE_W             = 8;
  localparam int CFG_W              = 6;
  localparam int SHARE_W            = 4;
  localparam int CFG_IDX_W          = 2;
  localparam int LETTER_SCALE       = 10;

  localparam logic [CFG_W-1:0]   MIN_LEN_RST = CFG_W'(3);
  localparam logic [CFG_W-1:0]   MAX_LEN_RST = CFG_W'(32);
  localparam logic [SHARE_W-1:0] SHARE_RST   = SHARE_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WORD_LENGTH     = 2'd0,
    CFG_MAX_WORD_LENGTH     = 2'd1,
    CFG_LETTER_SHARE_TENTHS = 2'd2
  } cfg_index_t;

  // Bank handed back by the emitter once its last byte has been read
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/word_tokenizer_filter.sv =====
// ----------------------------------------------------------------------------
// word_tokenizer_filter
// Whitespace word tokenizer with length and letter-share filter.
// ----------------------------------------------------------------------------
// Text enters on the s_ stream, one byte per beat, s_tlast on the final byte
// of a text. Words split on space, tab, LF, VT, FF and CR. A word that meets
// the length limits and the letter share leaves on the m_ stream, one byte
// per beat, A-Z lowercased, m_tlast on its final byte. Rejected words and
// bare whitespace produce no beats.
// Bytes are written into one of two word banks as they arrive, so intake
// runs at one byte per cycle. An accepted word is queued and the other bank
// takes the next word; intake stalls only while both banks hold words not
// yet read out. The emitter reads one byte per cycle from the word store
// while m_tready is high. A word's descriptor passes the queue, then its
// bytes the read data register and the output register. When m_tready is
// low the output register holds its beat and the read pipeline holds behind
// it; intake carries on until both banks are full. Reset clears the counts,
// the queue and the output, and returns the registers to min 3, max 32,
// share seven tenths. The user must write configuration through cfg_we /
// cfg_index / cfg_data while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module word_tokenizer_filter #(
  parameter int MAX_WORD_BYTES = wtok_pkg::MAX_WORD_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [wtok_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wtok_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [wtok_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] text_byte
  input  wire logic                            s_tlast,   // end_of_text
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [wtok_pkg::BYTE_W-1:0]          m_tdata,   // [7:0] word_char
  output logic                                 m_tlast    // word_done
);
  import wtok_pkg::*;

  localparam int LEN_W     = $clog2(MAX_WORD_BYTES + 2);
  localparam int IDX_W     = $clog2(MAX_WORD_BYTES);
  localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

  logic               ram_we;
  logic [IDX_W:0]     ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IDX_W:0]     ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;
  logic               q_push;
  logic [LEN_W:0]     q_push_data;
  logic               q_pop;
  logic               q_valid;
  logic [LEN_W:0]     q_data;
  release_t           rel;

  wtok_front #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES),
    .LEN_W          (LEN_W),
    .IDX_W          (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .rel         (rel)
  );

  wtok_queue #(
    .WIDTH (LEN_W + 1)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  wtok_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wtok_back #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES),
    .LEN_W          (LEN_W),
    .IDX_W          (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== sv/wtok_ram.sv =====
// ----------------------------------------------------------------------------
// wtok_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wtok_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/wtok_front.sv =====
// ----------------------------------------------------------------------------
// wtok_front
// Byte intake: classify, store word bytes, count, judge at each boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module wtok_front #(
  parameter int MAX_WORD_BYTES = wtok_pkg::MAX_WORD_BYTES_DEF,
  parameter int LEN_W          = $clog2(MAX_WORD_BYTES + 2),
  parameter int IDX_W          = $clog2(MAX_WORD_BYTES)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [wtok_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wtok_pkg::CFG_W-1:0]       cfg_data,
  // text stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [wtok_pkg::BYTE_W-1:0]      s_tdata,
  input  wire logic                             s_tlast,
  // word store write side
  output logic                                  ram_we,
  output logic [IDX_W:0]                        ram_waddr,
  output logic [wtok_pkg::BYTE_W-1:0]           ram_wdata,
  // accepted word descriptor: {bank, length}
  output logic                                  q_push,
  output logic [LEN_W:0]                        q_push_data,
  input  wire wtok_pkg::release_t               rel
);
  import wtok_pkg::*;

  localparam int PROD_W = LEN_W + SHARE_W;

  logic [CFG_W-1:0]   min_len;
  logic [CFG_W-1:0]   max_len;
  logic [SHARE_W-1:0] share;
  logic               wr_bank;
  logic [LEN_W-1:0]   word_len;
  logic [LEN_W-1:0]   letters;
  logic [1:0]         busy;

  logic               accept;
  logic               space;
  logic               boundary;
  logic               room;
  logic [LEN_W-1:0]   word_len_next;
  logic [LEN_W-1:0]   letters_next;
  logic [PROD_W-1:0]  letter_prod;
  logic [PROD_W-1:0]  share_prod;
  logic               word_ok;
  logic [1:0]         busy_next;

  assign s_tready = !busy[wr_bank];
  assign accept   = s_tvalid && s_tready;
  assign space    = is_space(s_tdata);
  assign boundary = space || s_tlast;
  assign room     = word_len < LEN_W'(MAX_WORD_BYTES);

  always_comb begin
    word_len_next = word_len;
    letters_next  = letters;
    if (!space) begin
      if (room) begin
        word_len_next = word_len + LEN_W'(1);
        letters_next  = letters + LEN_W'(is_letter(s_tdata));
      end else begin
        word_len_next = LEN_W'(MAX_WORD_BYTES + 1);
      end
    end
  end

  // release and claim always touch different banks
  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (q_push) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  assign letter_prod = PROD_W'(letters_next) * PROD_W'(LETTER_SCALE);
  assign share_prod  = PROD_W'(share) * PROD_W'(word_len_next);

  assign word_ok = (word_len_next != '0)
                && (PROD_W'(word_len_next) >= PROD_W'(min_len))
                && (PROD_W'(word_len_next) <= PROD_W'(max_len))
                && (word_len_next <= LEN_W'(MAX_WORD_BYTES))
                && (letter_prod >= share_prod);

  assign ram_we      = accept && !space && room;
  assign ram_waddr   = {wr_bank, word_len[IDX_W-1:0]};
  assign ram_wdata   = s_tdata;
  assign q_push      = accept && boundary && word_ok;
  assign q_push_data = {wr_bank, word_len_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len  <= MIN_LEN_RST;
      max_len  <= MAX_LEN_RST;
      share    <= SHARE_RST;
      wr_bank  <= 1'b0;
      word_len <= '0;
      letters  <= '0;
      busy     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_MIN_WORD_LENGTH:     min_len <= cfg_data;
          CFG_MAX_WORD_LENGTH:     max_len <= cfg_data;
          CFG_LETTER_SHARE_TENTHS: share   <= cfg_data[SHARE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (boundary) begin
          word_len <= '0;
          letters  <= '0;
        end else begin
          word_len <= word_len_next;
          letters  <= letters_next;
        end
      end
      busy <= busy_next;
      if (q_push) begin
        wr_bank <= !wr_bank;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/wtok_queue.sv =====
// ----------------------------------------------------------------------------
// wtok_queue
// Two-entry descriptor queue between intake and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module wtok_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic      [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign pop_valid = count != 2'd0;
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== sv/wtok_back.sv =====
// ----------------------------------------------------------------------------
// wtok_back
// Emitter: read each accepted word from its bank and send it byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wtok_back #(
  parameter int MAX_WORD_BYTES = wtok_pkg::MAX_WORD_BYTES_DEF,
  parameter int LEN_W          = $clog2(MAX_WORD_BYTES + 2),
  parameter int IDX_W          = $clog2(MAX_WORD_BYTES)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // descriptor queue: {bank, length}
  input  wire logic                         q_valid,
  input  wire logic [LEN_W:0]               q_data,
  output logic                              q_pop,
  // word store read side
  output logic                              ram_re,
  output logic [IDX_W:0]                    ram_raddr,
  input  wire logic [wtok_pkg::BYTE_W-1:0]  ram_rdata,
  output wtok_pkg::release_t                rel,
  // word stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [wtok_pkg::BYTE_W-1:0]       m_tdata,
  output logic                              m_tlast
);
  import wtok_pkg::*;

  logic               active;
  logic               cur_bank;
  logic [LEN_W-1:0]   cur_len;
  logic [LEN_W-1:0]   rd_idx;
  logic               s1_valid;
  logic               s1_last;

  logic               s2_free;
  logic               s1_move;
  logic               issue;
  logic               last_issue;

  assign s2_free    = !m_tvalid || m_tready;
  assign s1_move    = s1_valid && s2_free;
  assign issue      = active && (!s1_valid || s1_move);
  assign last_issue = issue && (rd_idx + LEN_W'(1) == cur_len);
  assign q_pop      = q_valid && (!active || last_issue);

  assign ram_re     = issue;
  assign ram_raddr  = {cur_bank, rd_idx[IDX_W-1:0]};
  assign rel.valid  = last_issue;
  assign rel.bank   = cur_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        active   <= 1'b1;
        cur_bank <= q_data[LEN_W];
        cur_len  <= q_data[LEN_W-1:0];
        rd_idx   <= '0;
      end else if (last_issue) begin
        active <= 1'b0;
      end else if (issue) begin
        rd_idx <= rd_idx + LEN_W'(1);
      end

      // read data register is the first stage; it holds while stalled
      if (issue) begin
        s1_valid <= 1'b1;
        s1_last  <= last_issue;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        m_tvalid <= 1'b1;
        m_tdata  <= lower_byte(ram_rdata);
        m_tlast  <= s1_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/wtok_checker.sv =====
// ----------------------------------------------------------------------------
// wtok_checker
// Port-level checks on the word stream of the tokenizer filter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_tokenizer_filter_defines.svh"

module wtok_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [wtok_pkg::BYTE_W-1:0] m_tdata,
  input wire logic                        m_tlast
);

  // a stalled beat must hold
  `WTOK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast), "word beat changed under stall")

  // emitted bytes are lowercased
  `WTOK_ASSERT_SAME(a_out_lower, m_tvalid,
    m_tdata < 8'h41 || m_tdata > 8'h5A, "upper-case letter in word stream")

  // words never carry a separator byte
  `WTOK_ASSERT_SAME(a_out_no_space, m_tvalid,
    m_tdata != 8'h20 && (m_tdata < 8'h09 || m_tdata > 8'h0D),
    "whitespace byte in word stream")

endmodule

bind word_tokenizer_filter wtok_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
